>>> hdl/rc4_pkg.sv
// rc4 package: shared constants, controller states and the command and
// status structs between the controller and the datapath. no dependencies.
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W      = 8;
    localparam int BOX_DEPTH   = 256;
    localparam int KEY_MAX_DEF = 32;

    // controller states
    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_KEY,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_WI,
        ST_KS_WJ,
        ST_KS_DONE,
        ST_PR_I,
        ST_PR_J,
        ST_PR_WI,
        ST_PR_WJ,
        ST_PR_OUT
    } t_state;

    // datapath commands, at most one step command per cycle
    typedef struct packed {
        logic in_load;
        logic store_key;
        logic fill;
        logic ks_rd;
        logic ks_j;
        logic ks_wi;
        logic ks_wj;
        logic ks_done;
        logic pr_i;
        logic pr_j;
        logic pr_wi;
        logic pr_wj;
        logic out_load;
    } t_dp_cmd;

    // datapath status
    typedef struct packed {
        logic idx_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hdl/rc4_ctrl.sv
// rc4 controller: state machine sequencing clearing pass, key schedule and
// keystream steps. depends on rc4_pkg.
`default_nettype none

module rc4_ctrl
    import rc4_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_kind,
    input  wire logic    i_last_key_byte,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state, n_state;
    logic   r_last;
    logic   accept;

    assign accept     = (r_state == ST_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != ST_IDLE);

    // state and last-key mark registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FILL;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_last <= i_last_key_byte;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_FILL: begin
                if (i_sts.idx_last) begin
                    n_state = r_last ? ST_KS_RD : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_kind ? ST_PR_I : ST_KEY;
                end
            end
            ST_KEY:     n_state = r_last ? ST_FILL : ST_IDLE;
            ST_KS_RD:   n_state = ST_KS_J;
            ST_KS_J:    n_state = ST_KS_WI;
            ST_KS_WI:   n_state = ST_KS_WJ;
            ST_KS_WJ:   n_state = i_sts.idx_last ? ST_KS_DONE : ST_KS_RD;
            ST_KS_DONE: n_state = ST_IDLE;
            ST_PR_I:    n_state = ST_PR_J;
            ST_PR_J:    n_state = ST_PR_WI;
            ST_PR_WI:   n_state = ST_PR_WJ;
            ST_PR_WJ:   n_state = ST_PR_OUT;
            ST_PR_OUT: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_FILL;
        endcase
    end

    // command decode
    always_comb begin
        o_cmd         = '0;
        o_cmd.in_load = accept;
        case (r_state)
            ST_FILL:    o_cmd.fill      = 1'b1;
            ST_KEY:     o_cmd.store_key = 1'b1;
            ST_KS_RD:   o_cmd.ks_rd     = 1'b1;
            ST_KS_J:    o_cmd.ks_j      = 1'b1;
            ST_KS_WI:   o_cmd.ks_wi     = 1'b1;
            ST_KS_WJ:   o_cmd.ks_wj     = 1'b1;
            ST_KS_DONE: o_cmd.ks_done   = 1'b1;
            ST_PR_I:    o_cmd.pr_i      = 1'b1;
            ST_PR_J:    o_cmd.pr_j      = 1'b1;
            ST_PR_WI:   o_cmd.pr_wi     = 1'b1;
            ST_PR_WJ:   o_cmd.pr_wj     = 1'b1;
            ST_PR_OUT:  o_cmd.out_load  = i_sts.out_free;
            default:    o_cmd.fill      = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

>>> hdl/rc4_dp.sv
// rc4 datapath: permutation box and key store memories, indices, key count
// and the output register. depends on rc4_pkg.
`default_nettype none

module rc4_dp
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic [BYTE_W-1:0] i_byte_in,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic [BYTE_W-1:0]      o_byte_out
);

    localparam int CNT_W  = $clog2(KEY_MAX + 1);
    localparam int KIDX_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    // memories
    logic [BYTE_W-1:0] r_box [BOX_DEPTH];
    logic [BYTE_W-1:0] r_key [KEY_MAX];
    logic [BYTE_W-1:0] r_box_rdata;
    logic [BYTE_W-1:0] r_kdata;

    // control registers
    logic [BYTE_W-1:0] r_n;
    logic [BYTE_W-1:0] r_i;
    logic [BYTE_W-1:0] r_j;
    logic [CNT_W-1:0]  r_count;
    logic [KIDX_W-1:0] r_k;
    logic              r_out_valid;

    // payload registers
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] r_si;
    logic [BYTE_W-1:0] r_sj;
    logic              r_fwd;
    logic [BYTE_W-1:0] r_byte_out;

    logic              box_we;
    logic [BYTE_W-1:0] box_waddr;
    logic [BYTE_W-1:0] box_wdata;
    logic              box_re;
    logic [BYTE_W-1:0] box_raddr;
    logic [BYTE_W-1:0] j_sum;
    logic [BYTE_W-1:0] inc_i;
    logic [BYTE_W-1:0] ks_addr;
    logic [CNT_W-1:0]  k_next;
    logic              out_free;

    assign j_sum    = r_j + r_kdata + r_box_rdata;
    assign inc_i    = r_i + BYTE_W'(1);
    assign ks_addr  = r_si + r_sj;
    assign k_next   = CNT_W'(r_k) + CNT_W'(1);
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_sts.idx_last = (r_n == BYTE_W'(BOX_DEPTH - 1));
    assign o_sts.out_free = out_free;
    assign o_out_valid    = r_out_valid;
    assign o_byte_out     = r_byte_out;

    // box port address and data selection
    always_comb begin
        box_we    = 1'b0;
        box_waddr = r_n;
        box_wdata = r_n;
        box_re    = 1'b0;
        box_raddr = r_n;
        if (i_cmd.fill) begin
            box_we = 1'b1;
        end else if (i_cmd.ks_rd) begin
            box_re = 1'b1;
        end else if (i_cmd.ks_j) begin
            box_re    = 1'b1;
            box_raddr = j_sum;
        end else if (i_cmd.ks_wi) begin
            box_we    = 1'b1;
            box_wdata = r_box_rdata;
        end else if (i_cmd.ks_wj) begin
            box_we    = 1'b1;
            box_waddr = r_j;
            box_wdata = r_si;
        end else if (i_cmd.pr_i) begin
            box_re    = 1'b1;
            box_raddr = inc_i;
        end else if (i_cmd.pr_j) begin
            box_re    = 1'b1;
            box_raddr = r_j + r_box_rdata;
        end else if (i_cmd.pr_wi) begin
            box_we    = 1'b1;
            box_waddr = r_i;
            box_wdata = r_box_rdata;
        end else if (i_cmd.pr_wj) begin
            box_we    = 1'b1;
            box_waddr = r_j;
            box_wdata = r_si;
            box_re    = 1'b1;
            box_raddr = ks_addr;
        end
    end

    // permutation box, registered read returns old data
    always_ff @(posedge i_clk) begin
        if (box_we) begin
            r_box[box_waddr] <= box_wdata;
        end
        if (box_re) begin
            r_box_rdata <= r_box[box_raddr];
        end
    end

    // key store
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_key && (r_count < CNT_W'(KEY_MAX))) begin
            r_key[r_count[KIDX_W-1:0]] <= r_byte;
        end
        if (i_cmd.ks_rd) begin
            r_kdata <= r_key[r_k];
        end
    end

    // indices, counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_count     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fill) begin
                r_n <= r_n + BYTE_W'(1);
                r_j <= '0;
                r_k <= '0;
            end
            if (i_cmd.store_key && (r_count < CNT_W'(KEY_MAX))) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.ks_j) begin
                r_j <= j_sum;
            end
            if (i_cmd.ks_wj) begin
                r_n <= r_n + BYTE_W'(1);
                r_k <= (k_next == r_count) ? '0 : k_next[KIDX_W-1:0];
            end
            if (i_cmd.ks_done) begin
                r_i     <= '0;
                r_j     <= '0;
                r_count <= '0;
            end
            if (i_cmd.pr_i) begin
                r_i <= inc_i;
            end
            if (i_cmd.pr_j) begin
                r_j <= r_j + r_box_rdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // byte latch, swap operands and output data
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_byte <= i_byte_in;
        end
        if (i_cmd.ks_j || i_cmd.pr_j) begin
            r_si <= r_box_rdata;
        end
        if (i_cmd.pr_wi) begin
            r_sj <= r_box_rdata;
        end
        // keystream address hits the entry being written this cycle
        if (i_cmd.pr_wj) begin
            r_fwd <= (ks_addr == r_j);
        end
        if (i_cmd.out_load) begin
            r_byte_out <= r_byte ^ (r_fwd ? r_si : r_box_rdata);
        end
    end

endmodule

`default_nettype wire

>>> hdl/rc4_stream_cipher.sv
// rc4 stream cipher top level: joins the controller and the datapath.
// depends on rc4_pkg, rc4_ctrl and rc4_dp.
`default_nettype none

// RC4 stream cipher. Key bytes (kind 0) are collected, up to KEY_MAX; the
// byte marked last starts the key schedule. Data bytes (kind 1) come back
// XORed with the next keystream byte; encryption and decryption are the
// same. The permutation box is a 256 x 8 memory with one write and one
// registered read port, and its access sequence sets the timing: a data
// byte is accepted, then takes 4 box steps and the output load before the
// next acceptance, the load waiting while a previous result still sits on a
// stalled output; a key byte takes a store step, and the last key byte adds
// an identity fill, a key schedule (4 box steps per swap) and a closing
// step. After reset the box is set to the identity by a clearing pass while
// the input stays stalled. A finished result waits in the output register,
// and the next item is accepted meanwhile.
module rc4_stream_cipher
    import rc4_pkg::*;
#(
    parameter int KEY_MAX = KEY_MAX_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_kind,
    input  wire logic [BYTE_W-1:0] i_byte_in,
    input  wire logic              i_last_key_byte,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [BYTE_W-1:0]      o_byte_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing
    rc4_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_kind          (i_kind),
        .i_last_key_byte (i_last_key_byte),
        .o_in_stall      (o_in_stall),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // box, key store and output register
    rc4_dp #(
        .KEY_MAX (KEY_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_byte_in   (i_byte_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_byte_out  (o_byte_out)
    );

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
// testbench for rc4_stream_cipher: directed and random key and data traffic,
// checked against an in-bench rc4 predictor. depends on rc4_pkg and the rtl.

module tb;
    import rc4_pkg::*;

    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;
    localparam int   IDLE_LIMIT   = 20000;
    localparam int   SETTLE_TICKS = 1600;
    localparam int   HOLD_TICKS   = 500;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_kind = KIND_KEY;
    logic [BYTE_W-1:0] i_byte_in = '0;
    logic              i_last_key_byte = 1'b0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [BYTE_W-1:0] o_byte_out;

    rc4_stream_cipher dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_byte_in      (i_byte_in),
        .i_last_key_byte(i_last_key_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_byte_out     (o_byte_out)
    );

    // cipher state mirrored by the predictor
    logic [BYTE_W-1:0] sbox [BOX_DEPTH];
    logic [BYTE_W-1:0] gen_i;
    logic [BYTE_W-1:0] gen_j;
    logic [BYTE_W-1:0] key_buf [KEY_MAX_DEF];
    int unsigned       key_len;

    logic [BYTE_W-1:0] cipher_bytes_due [$];

    int unsigned errors        = 0;
    int unsigned n_checked     = 0;
    int unsigned n_schedules   = 0;
    int unsigned n_key_bytes   = 0;
    int unsigned n_overflow    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_active   = 1'b0;
    int unsigned idle_ticks    = 0;

    // clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // predictor
    function automatic void sbox_swap(input int unsigned a, input int unsigned b);
        logic [BYTE_W-1:0] t;
        t = sbox[a & 255];
        sbox[a & 255] = sbox[b & 255];
        sbox[b & 255] = t;
    endfunction

    function automatic void sbox_identity();
        for (int n = 0; n < BOX_DEPTH; n++) sbox[n] = BYTE_W'(n);
    endfunction

    function automatic void run_key_schedule();
        logic [BYTE_W-1:0] j;
        int unsigned len;
        len = key_len;
        // marked byte is stored unless the store is full, so an empty key is only a guard
        if (len == 0) begin
            key_buf[0] = '0;
            len = 1;
        end
        sbox_identity();
        j = '0;
        for (int n = 0; n < BOX_DEPTH; n++) begin
            j = j + key_buf[n % len] + sbox[n];
            sbox_swap(n, j);
        end
        gen_i = '0;
        gen_j = '0;
        key_len = 0;
    endfunction

    function automatic logic [BYTE_W-1:0] keystream_next();
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + sbox[gen_i];
        sbox_swap(gen_i, gen_j);
        return sbox[8'(sbox[gen_i] + sbox[gen_j])];
    endfunction

    function automatic void cipher_predict(input logic kind, input logic [BYTE_W-1:0] b,
                                           input logic last);
        if (kind == KIND_KEY) begin
            // bytes past the key store are dropped, count stays saturated
            if (key_len < KEY_MAX_DEF) begin
                key_buf[key_len] = b;
                key_len++;
                n_key_bytes++;
            end else begin
                n_overflow++;
            end
            if (last) begin
                run_key_schedule();
                n_schedules++;
            end
        end else begin
            cipher_bytes_due.push_back(b ^ keystream_next());
        end
    endfunction

    // receiver stall, random plus the long hold-off
    always @(posedge i_clk) begin
        i_out_stall <= hold_active || ($urandom_range(0, 99) < recv_stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        logic [BYTE_W-1:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cipher_bytes_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %02h",
                         $time, o_byte_out);
                errors++;
            end else begin
                want = cipher_bytes_due.pop_front();
                if (o_byte_out !== want) begin
                    $display("%0t: byte_out mismatch, expected %02h, actual %02h",
                             $time, want, o_byte_out);
                    errors++;
                end else begin
                    n_checked++;
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_ticks <= 0;
        end else if (idle_ticks >= IDLE_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, idle_ticks);
            $display("tb: errors");
            $finish;
        end else begin
            idle_ticks <= idle_ticks + 1;
        end
    end

    // one input transaction; valid stays high for a back-to-back follower
    task automatic send_item(input logic kind, input logic [BYTE_W-1:0] b, input logic last);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_kind          <= kind;
        i_byte_in       <= b;
        i_last_key_byte <= last;
        do @(posedge i_clk); while (o_in_stall);
        cipher_predict(kind, b, last);
    endtask

    task automatic send_key(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_item(KIND_KEY, BYTE_W'($urandom), k == len - 1);
    endtask

    // data bytes, occasionally with a stray last mark that must be ignored
    task automatic send_data_run(input int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            send_item(KIND_DATA, BYTE_W'($urandom), $urandom_range(0, 7) == 0);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct <= recv_pct;
    endtask

    // data with the identity box straight after reset
    task automatic test_data_before_key();
        send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'hff, 1'b0);
        send_item(KIND_DATA, 8'h5a, 1'b0);
    endtask

    // one-byte keys at both byte extremes
    task automatic test_single_byte_keys();
        send_item(KIND_KEY, 8'h00, 1'b1);
        send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'hff, 1'b0);
        send_item(KIND_KEY, 8'hff, 1'b1);
        send_item(KIND_DATA, 8'haa, 1'b0);
        send_item(KIND_DATA, 8'h55, 1'b0);
    endtask

    // last mark on data items has no effect
    task automatic test_data_last_mark();
        send_item(KIND_DATA, 8'h01, 1'b1);
        send_item(KIND_DATA, 8'h80, 1'b1);
        send_item(KIND_DATA, 8'h7f, 1'b0);
    endtask

    // data while a key is half collected, then the key completes
    task automatic test_partial_key();
        send_item(KIND_KEY, 8'h12, 1'b0);
        send_item(KIND_KEY, 8'hed, 1'b0);
        send_item(KIND_DATA, 8'h33, 1'b0);
        send_item(KIND_DATA, 8'hcc, 1'b0);
        send_item(KIND_KEY, 8'h9c, 1'b1);
        send_item(KIND_DATA, 8'h00, 1'b0);
        send_item(KIND_DATA, 8'hff, 1'b0);
    endtask

    // full store, then overflow with the marked byte itself dropped
    task automatic test_key_overflow();
        send_key(KEY_MAX_DEF);
        send_data_run(2);
        send_key(KEY_MAX_DEF + 2);
        send_data_run(3);
    endtask

    // output held off long enough that the input side has to stall
    task automatic test_output_holdoff();
        fork
            begin
                hold_active <= 1'b1;
                repeat (HOLD_TICKS) @(posedge i_clk);
                hold_active <= 1'b0;
            end
            send_data_run(24);
        join
    endtask

    // mostly well-formed key-then-data sequences, some data-only and partial keys
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        int unsigned run;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            run  = $urandom_range(1, 40);
            if (pick < 70) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 16);
                    6, 7:             len = $urandom_range(17, KEY_MAX_DEF - 1);
                    default:          len = $urandom_range(KEY_MAX_DEF, KEY_MAX_DEF + 8);
                endcase
                send_key(len);
                sent += len;
            end else if (pick >= 85) begin
                len = $urandom_range(1, 4);
                for (int unsigned k = 0; k < len; k++)
                    send_item(KIND_KEY, BYTE_W'($urandom), 1'b0);
                sent += len;
            end
            send_data_run(run);
            sent += run;
        end
    endtask

    // stop offering and wait for every predicted byte
    task automatic drain();
        i_in_valid <= 1'b0;
        while (cipher_bytes_due.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        key_len = 0;
        gen_i   = '0;
        gen_j   = '0;
        sbox_identity();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, no idling
        test_data_before_key();
        test_single_byte_keys();
        test_data_last_mark();
        test_partial_key();
        test_key_overflow();
        test_output_holdoff();

        // random, one idling pattern per phase
        set_idling(0, 0);
        test_random_traffic(320);
        set_idling(82, 0);
        test_random_traffic(320);
        set_idling(0, 82);
        test_random_traffic(320);
        set_idling(9, 9);
        test_random_traffic(320);

        set_idling(0, 0);
        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (cipher_bytes_due.size() != 0) begin
            $display("%0t: %0d expected bytes never arrived", $time, cipher_bytes_due.size());
            errors++;
        end

        $display("tb: %0d key schedules, %0d key bytes stored, %0d dropped on overflow",
                 n_schedules, n_key_bytes, n_overflow);
        $display("tb: %0d data bytes checked over four idling phases and an output hold-off",
                 n_checked);
        if (errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/rc4_pkg.sv
hdl/rc4_ctrl.sv
hdl/rc4_dp.sv
hdl/rc4_stream_cipher.sv
tb/tb.sv
